FILE: hdl/xcrc_pkg.sv
// Package for the XMODEM-CRC packet receiver: beat payload types, framing and
// status codes, and the CRC-16 (0x1021) byte update. No dependencies.
package xcrc_pkg;

    // Framing bytes seen in the idle phase
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_CAN = 8'h18;

    // Status codes
    localparam logic [2:0] ST_SHORT   = 3'd0;
    localparam logic [2:0] ST_LONG    = 3'd1;
    localparam logic [2:0] ST_CANCEL  = 3'd2;
    localparam logic [2:0] ST_END     = 3'd3;
    localparam logic [2:0] ST_ERROR   = 3'd4;
    localparam logic [2:0] ST_TIMEOUT = 3'd5;
    localparam logic [2:0] ST_DUP     = 3'd6;

    // CRC-16 constants
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_TOPBIT = 16'h8000;

    // Input beat
    typedef struct packed {
        logic       is_timeout;
        logic [7:0] rx_byte;
        logic [7:0] expected_seq;
    } xcrc_in_t;

    // Result beat
    typedef struct packed {
        logic        is_status;
        logic [7:0]  payload_byte;
        logic [9:0]  byte_index;
        logic [2:0]  status_code;
        logic [10:0] payload_length;
    } xcrc_out_t;

    // One byte through the CRC, MSB first, eight shift steps
    function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOPBIT) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/xcrc_stream_if.sv
// Valid/ready stream channel carrying one payload beat of a chosen type.
// Stand-alone; the payload type is given where the channel is instantiated.
interface xcrc_stream_if #(parameter type payload_t = logic [0:0]) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/xmodem_crc_packet_receiver_top.sv
// Top level of the XMODEM-CRC packet receiver (128-byte and 1K blocks).
// Depends on xcrc_pkg and on xcrc_stream_if (item: xcrc_in_t, result: xcrc_out_t).

// The block takes one beat per clock on item (a received byte or a timeout) and
// gives at most one beat on result: a payload byte with its index, or an
// end-of-packet status with its length. A beat passes an input register, then
// the framing state machine and a combinational CRC byte update, then the result
// register, from which its result is presented on result. One beat per cycle is
// sustained; the only stall comes from result.ready held low while the result
// register is full, which holds the beat in the input register.
module xmodem_crc_packet_receiver_top #(
    parameter int SHORT_BLOCK = 128,
    parameter int LONG_BLOCK  = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    xcrc_stream_if.sink   item,
    xcrc_stream_if.source result
);
    import xcrc_pkg::*;

    localparam logic [10:0] SHORT_SIZE = 11'(SHORT_BLOCK);
    localparam logic [10:0] LONG_SIZE  = 11'(LONG_BLOCK);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SEQ   = 3'd1,
        PH_INV   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CRCHI = 3'd4,
        PH_CRCLO = 3'd5
    } phase_t;

    // Input register
    logic        in_valid_reg;
    xcrc_in_t    in_data_reg;

    // Framing state
    phase_t      phase_reg, phase_next;
    logic        long_block_reg, long_block_next;
    logic [7:0]  seq_number_reg, seq_number_next;
    logic [2:0]  pending_status_reg, pending_status_next;
    logic [10:0] byte_counter_reg, byte_counter_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [7:0]  trailer_high_reg, trailer_high_next;
    logic [7:0]  expected_latched_reg, expected_latched_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    xcrc_out_t   out_data_reg, out_data_next;

    logic        advance;
    logic        emit;
    xcrc_out_t   emit_data;
    logic [10:0] block_size;
    logic [10:0] count_inc;

    // Handshake
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready   = !in_valid_reg || advance;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    assign block_size = long_block_reg ? LONG_SIZE : SHORT_SIZE;
    assign count_inc  = byte_counter_reg + 11'd1;

    // Framing and CRC for the beat in the input register
    always_comb
    begin
        phase_next            = phase_reg;
        long_block_next       = long_block_reg;
        seq_number_next       = seq_number_reg;
        pending_status_next   = pending_status_reg;
        byte_counter_next     = byte_counter_reg;
        running_crc_next      = running_crc_reg;
        trailer_high_next     = trailer_high_reg;
        expected_latched_next = expected_latched_reg;
        emit                  = 1'b0;
        emit_data             = '0;

        unique case (phase_reg)
            PH_SEQ, PH_INV, PH_DATA, PH_CRCHI, PH_CRCLO:
            begin
                if (in_data_reg.is_timeout)
                begin
                    emit                  = 1'b1;
                    emit_data.is_status   = 1'b1;
                    emit_data.status_code = ST_TIMEOUT;
                    if (phase_reg == PH_DATA || phase_reg == PH_CRCHI
                        || phase_reg == PH_CRCLO)
                    begin
                        emit_data.payload_length = byte_counter_reg;
                    end
                    phase_next = PH_IDLE;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_SEQ:
                        begin
                            seq_number_next       = in_data_reg.rx_byte;
                            expected_latched_next = in_data_reg.expected_seq;
                            phase_next            = PH_INV;
                        end
                        PH_INV:
                        begin
                            pending_status_next = long_block_reg ? ST_LONG : ST_SHORT;
                            if (seq_number_reg != ~in_data_reg.rx_byte
                                || seq_number_reg != expected_latched_reg)
                            begin
                                pending_status_next = ST_ERROR;
                            end
                            // previous packet resent
                            if (seq_number_reg == expected_latched_reg - 8'd1)
                            begin
                                pending_status_next = ST_DUP;
                            end
                            byte_counter_next = '0;
                            running_crc_next  = '0;
                            phase_next        = PH_DATA;
                        end
                        PH_DATA:
                        begin
                            emit                   = 1'b1;
                            emit_data.payload_byte = in_data_reg.rx_byte;
                            emit_data.byte_index   = byte_counter_reg[9:0];
                            running_crc_next  = crc16_byte(running_crc_reg,
                                                           in_data_reg.rx_byte);
                            byte_counter_next = count_inc;
                            if (count_inc >= block_size)
                            begin
                                phase_next = PH_CRCHI;
                            end
                        end
                        PH_CRCHI:
                        begin
                            trailer_high_next = in_data_reg.rx_byte;
                            phase_next        = PH_CRCLO;
                        end
                        default:
                        begin
                            emit                = 1'b1;
                            emit_data.is_status = 1'b1;
                            if (running_crc_reg != {trailer_high_reg, in_data_reg.rx_byte})
                            begin
                                emit_data.status_code = ST_ERROR;
                            end
                            else
                            begin
                                emit_data.status_code    = pending_status_reg;
                                emit_data.payload_length = byte_counter_reg;
                            end
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            // idle and unused codes: wait for a header or control event
            default:
            begin
                if (in_data_reg.is_timeout)
                begin
                    emit                  = 1'b1;
                    emit_data.is_status   = 1'b1;
                    emit_data.status_code = ST_TIMEOUT;
                    phase_next            = PH_IDLE;
                end
                else if (in_data_reg.rx_byte == BYTE_EOT)
                begin
                    emit                  = 1'b1;
                    emit_data.is_status   = 1'b1;
                    emit_data.status_code = ST_END;
                    phase_next            = PH_IDLE;
                end
                else if (in_data_reg.rx_byte == BYTE_CAN)
                begin
                    emit                  = 1'b1;
                    emit_data.is_status   = 1'b1;
                    emit_data.status_code = ST_CANCEL;
                    phase_next            = PH_IDLE;
                end
                else if (in_data_reg.rx_byte == BYTE_SOH
                         || in_data_reg.rx_byte == BYTE_STX)
                begin
                    long_block_next   = (in_data_reg.rx_byte == BYTE_STX);
                    byte_counter_next = '0;
                    running_crc_next  = '0;
                    phase_next        = PH_SEQ;
                end
            end
        endcase
    end

    // Result register next value
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                out_data_next = emit_data;
            end
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State, input register and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            in_data_reg          <= '0;
            out_valid_reg        <= 1'b0;
            out_data_reg         <= '0;
            phase_reg            <= PH_IDLE;
            long_block_reg       <= 1'b0;
            seq_number_reg       <= '0;
            pending_status_reg   <= '0;
            byte_counter_reg     <= '0;
            running_crc_reg      <= '0;
            trailer_high_reg     <= '0;
            expected_latched_reg <= '0;
        end
        else
        begin
            if (item.valid && item.ready)
            begin
                in_valid_reg <= 1'b1;
                in_data_reg  <= item.data;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            if (advance)
            begin
                phase_reg            <= phase_next;
                long_block_reg       <= long_block_next;
                seq_number_reg       <= seq_number_next;
                pending_status_reg   <= pending_status_next;
                byte_counter_reg     <= byte_counter_next;
                running_crc_reg      <= running_crc_next;
                trailer_high_reg     <= trailer_high_next;
                expected_latched_reg <= expected_latched_next;
            end
        end
    end

    // Assertions
    a_status_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit && emit_data.is_status) |=> (phase_reg == PH_IDLE))
        else $error("status beat did not return the framer to idle");

    a_payload_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.is_status)
            |-> (out_data_reg.status_code == ST_SHORT && out_data_reg.payload_length == 11'd0))
        else $error("payload beat carries status fields");

    a_count_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (byte_counter_reg < block_size))
        else $error("byte counter ran past the block size");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (in_valid_reg && out_valid_reg && !result.ready))
        else $error("input stalled without back-pressure");

endmodule

FILE: tb/sv/xmodem_crc_packet_receiver_top_tb.sv
// Self-checking testbench for the XMODEM-CRC packet receiver top level.
// Depends on xcrc_pkg, xcrc_stream_if and xmodem_crc_packet_receiver_top; predicts every
// result beat from its own framing/CRC model and compares it in order.
module xmodem_crc_packet_receiver_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xcrc_pkg::*;

    localparam int SHORT_SIZE     = 128;
    localparam int LONG_SIZE      = 1024;
    localparam int RANDOM_ITEMS   = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    // Framing phases of the predictor
    typedef enum logic [2:0] {
        RX_IDLE,
        RX_SEQ,
        RX_INV,
        RX_DATA,
        RX_CRC_HI,
        RX_CRC_LO
    } rx_phase_t;

    // Kinds of packet the stimulus builds
    typedef enum int {
        PK_GOOD,
        PK_DUP,
        PK_BAD_SEQ,
        PK_BAD_INV,
        PK_BAD_CRC
    } pkt_kind_t;

    logic clk;
    logic rst_n;

    xcrc_stream_if #(.payload_t(xcrc_in_t))  rx_ch ();
    xcrc_stream_if #(.payload_t(xcrc_out_t)) res_ch ();

    xmodem_crc_packet_receiver_top #(
        .SHORT_BLOCK(SHORT_SIZE),
        .LONG_BLOCK (LONG_SIZE)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (rx_ch),
        .result(res_ch)
    );

    // Predictor state
    rx_phase_t   rx_phase;
    logic        rx_long;
    logic [7:0]  rx_seq;
    logic [7:0]  rx_exp;
    logic [2:0]  rx_pending;
    logic [10:0] rx_count;
    logic [15:0] rx_crc;
    logic [7:0]  rx_trailer_hi;

    xcrc_out_t predicted_results[$];
    int        mismatch_count;
    int        live_items;
    bit        idle_enable;
    bit        hold_request;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // CRC-16, polynomial 0x1021, MSB first
    function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] data_v);
        logic [15:0] c;
        c = crc ^ {data_v, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOPBIT) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic xcrc_in_t make_beat(logic tmo, logic [7:0] data_v, logic [7:0] exp_v);
        xcrc_in_t b;
        b.is_timeout   = tmo;
        b.rx_byte      = data_v;
        b.expected_seq = exp_v;
        return b;
    endfunction

    // Deframer prediction for one accepted beat; queues the result it causes
    task automatic predict_receiver(input xcrc_in_t b);
        xcrc_out_t   r;
        bit          emit;
        bit          was_busy;
        logic [7:0]  prev_seq;
        logic [10:0] size;
        r        = '0;
        emit     = 1'b0;
        was_busy = (rx_phase != RX_IDLE);
        size     = rx_long ? 11'(LONG_SIZE) : 11'(SHORT_SIZE);
        if (rx_phase == RX_IDLE)
        begin
            if (b.is_timeout)
            begin
                emit = 1'b1;
                r.is_status   = 1'b1;
                r.status_code = ST_TIMEOUT;
            end
            else if (b.rx_byte == BYTE_EOT)
            begin
                emit = 1'b1;
                r.is_status   = 1'b1;
                r.status_code = ST_END;
            end
            else if (b.rx_byte == BYTE_CAN)
            begin
                emit = 1'b1;
                r.is_status   = 1'b1;
                r.status_code = ST_CANCEL;
            end
            else if (b.rx_byte == BYTE_SOH || b.rx_byte == BYTE_STX)
            begin
                rx_long  = (b.rx_byte == BYTE_STX);
                rx_count = '0;
                rx_crc   = '0;
                rx_phase = RX_SEQ;
                was_busy = 1'b1;
            end
        end
        else if (b.is_timeout)
        begin
            // Abort mid-packet: length counts payload bytes seen so far
            emit = 1'b1;
            r.is_status      = 1'b1;
            r.status_code    = ST_TIMEOUT;
            r.payload_length = (rx_phase >= RX_DATA) ? rx_count : 11'd0;
        end
        else
        begin
            case (rx_phase)
                RX_SEQ:
                begin
                    rx_seq   = b.rx_byte;
                    rx_exp   = b.expected_seq;
                    rx_phase = RX_INV;
                end
                RX_INV:
                begin
                    prev_seq   = rx_exp - 8'd1;
                    rx_pending = rx_long ? ST_LONG : ST_SHORT;
                    if (rx_seq != ~b.rx_byte || rx_seq != rx_exp)
                    begin
                        rx_pending = ST_ERROR;
                    end
                    // duplicate wins over error
                    if (rx_seq == prev_seq)
                    begin
                        rx_pending = ST_DUP;
                    end
                    rx_count = '0;
                    rx_crc   = '0;
                    rx_phase = RX_DATA;
                end
                RX_DATA:
                begin
                    emit = 1'b1;
                    r.payload_byte = b.rx_byte;
                    r.byte_index   = rx_count[9:0];
                    rx_crc   = crc_update(rx_crc, b.rx_byte);
                    rx_count = rx_count + 11'd1;
                    if (rx_count >= size)
                    begin
                        rx_phase = RX_CRC_HI;
                    end
                end
                RX_CRC_HI:
                begin
                    rx_trailer_hi = b.rx_byte;
                    rx_phase      = RX_CRC_LO;
                end
                default:
                begin
                    emit = 1'b1;
                    r.is_status = 1'b1;
                    if (rx_crc != {rx_trailer_hi, b.rx_byte})
                    begin
                        r.status_code = ST_ERROR;
                    end
                    else
                    begin
                        r.status_code    = rx_pending;
                        r.payload_length = rx_count;
                    end
                end
            endcase
        end
        if (emit && r.is_status)
        begin
            rx_phase = RX_IDLE;
        end
        if (emit)
        begin
            predicted_results.push_back(r);
        end
        if (was_busy || emit)
        begin
            live_items++;
        end
    endtask

    // Offer one input beat after a random gap and wait for it to be taken
    task automatic send_beat(input xcrc_in_t b);
        int gap;
        gap = idle_enable ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            rx_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid = 1'b1;
        rx_ch.data  = b;
        do
        begin
            @(posedge clk);
        end
        while (!rx_ch.ready);
        predict_receiver(b);
    endtask

    task automatic send_random_timeout();
        send_beat(make_beat(1'b1, 8'($urandom), 8'($urandom)));
    endtask

    // One packet; cut_at >= 0 replaces that beat by a timeout and stops there
    task automatic send_packet(input bit long_blk, input pkt_kind_t kind, input int cut_at,
                               input int exp_sel);
        xcrc_in_t    beats[$];
        logic [7:0]  exp_v;
        logic [7:0]  seq_v;
        logic [7:0]  inv_v;
        logic [7:0]  d;
        logic [15:0] crc;
        int          size;
        if (rx_phase != RX_IDLE)
        begin
            send_random_timeout();
        end
        size  = long_blk ? LONG_SIZE : SHORT_SIZE;
        exp_v = (exp_sel < 0) ? 8'($urandom) : 8'(exp_sel);
        seq_v = exp_v;
        inv_v = ~exp_v;
        case (kind)
            PK_DUP:
            begin
                seq_v = exp_v - 8'd1;
                inv_v = ($urandom_range(0, 1) != 0) ? ~seq_v : 8'($urandom);
            end
            PK_BAD_SEQ:
            begin
                do
                begin
                    seq_v = 8'($urandom);
                end
                while (seq_v == exp_v || seq_v == exp_v - 8'd1);
                inv_v = ~seq_v;
            end
            PK_BAD_INV:
            begin
                inv_v = ~seq_v ^ 8'($urandom_range(1, 255));
            end
            default:
            begin
            end
        endcase
        beats.push_back(make_beat(1'b0, long_blk ? BYTE_STX : BYTE_SOH, 8'($urandom)));
        beats.push_back(make_beat(1'b0, seq_v, exp_v));
        beats.push_back(make_beat(1'b0, inv_v, 8'($urandom)));
        crc = '0;
        for (int i = 0; i < size; i++)
        begin
            d   = 8'($urandom);
            crc = crc_update(crc, d);
            beats.push_back(make_beat(1'b0, d, 8'($urandom)));
        end
        if (kind == PK_BAD_CRC)
        begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        beats.push_back(make_beat(1'b0, crc[15:8], 8'($urandom)));
        beats.push_back(make_beat(1'b0, crc[7:0], 8'($urandom)));
        foreach (beats[i])
        begin
            if (i == cut_at)
            begin
                send_random_timeout();
                break;
            end
            send_beat(beats[i]);
        end
    endtask

    // Compare one result beat against the oldest prediction
    task automatic check_result(input xcrc_out_t got);
        xcrc_out_t want;
        if (predicted_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $display("[%0t] unexpected result beat: status=%0b byte=%02h idx=%0d code=%0d len=%0d",
                         $realtime, got.is_status, got.payload_byte, got.byte_index,
                         got.status_code, got.payload_length);
            end
            return;
        end
        want = predicted_results.pop_front();
        if (got.is_status != want.is_status || got.payload_byte != want.payload_byte ||
            got.byte_index != want.byte_index || got.status_code != want.status_code ||
            got.payload_length != want.payload_length)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $display("[%0t] result mismatch: exp status=%0b byte=%02h idx=%0d code=%0d len=%0d",
                         $realtime, want.is_status, want.payload_byte, want.byte_index,
                         want.status_code, want.payload_length);
                $display("[%0t]                  got status=%0b byte=%02h idx=%0d code=%0d len=%0d",
                         $realtime, got.is_status, got.payload_byte, got.byte_index,
                         got.status_code, got.payload_length);
            end
        end
    endtask

    // Result side: random ready gaps, one long hold-off on request
    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = idle_enable ? $urandom_range(0, 4) : 0;
            @(negedge clk);
            if (hold_request)
            begin
                res_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (gap > 0)
            begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!res_ch.valid);
            check_result(res_ch.data);
        end
    end

    // Watchdog on cycles with no beat moving on either channel
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Idle control bytes, ignored bytes and timeouts
    task automatic test_idle_events();
        send_beat(make_beat(1'b0, BYTE_EOT, 8'h00));
        send_beat(make_beat(1'b0, BYTE_CAN, 8'hFF));
        send_beat(make_beat(1'b1, 8'hFF, 8'hFF));
        send_beat(make_beat(1'b1, BYTE_SOH, 8'h00));
        send_beat(make_beat(1'b0, 8'h00, 8'h00));
        send_beat(make_beat(1'b0, 8'hFF, 8'hFF));
        send_beat(make_beat(1'b0, 8'h03, 8'h55));
        send_beat(make_beat(1'b0, 8'hAA, 8'hAA));
    endtask

    // Timeouts before the payload and early in it
    task automatic test_midpacket_timeouts();
        send_packet(1'b0, PK_GOOD, 1, 0);
        send_packet(1'b1, PK_GOOD, 2, 255);
        send_packet(1'b0, PK_GOOD, 5, -1);
        send_packet(1'b1, PK_GOOD, 4, -1);
    endtask

    // One short packet of every packet kind, sequence edges included
    task automatic test_short_statuses();
        send_packet(1'b0, PK_GOOD, -1, 255);
        send_packet(1'b0, PK_DUP, -1, 0);
        send_packet(1'b0, PK_BAD_SEQ, -1, -1);
        send_packet(1'b0, PK_BAD_INV, -1, 0);
        send_packet(1'b0, PK_BAD_CRC, -1, -1);
    endtask

    // Full 1K packet
    task automatic test_long_packets();
        send_packet(1'b1, PK_GOOD, -1, 0);
    endtask

    // Result side held off while the sender keeps the input busy
    task automatic test_output_backpressure();
        idle_enable  = 1'b0;
        hold_request = 1'b1;
        send_packet(1'b0, PK_GOOD, -1, -1);
        idle_enable = 1'b1;
    endtask

    // Short and truncated packets with random content, plus noise, control bytes and timeouts
    task automatic test_random_traffic();
        int        start_items;
        int        pick;
        int        kind_pick;
        bit        long_blk;
        pkt_kind_t kind;
        start_items = live_items;
        while (live_items - start_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                kind_pick = $urandom_range(0, 9);
                kind = (kind_pick < 5) ? PK_GOOD :
                       (kind_pick == 5) ? PK_DUP :
                       (kind_pick == 6) ? PK_BAD_SEQ :
                       (kind_pick == 7) ? PK_BAD_INV : PK_BAD_CRC;
                send_packet(1'b0, kind, -1, -1);
            end
            else if (pick < 65)
            begin
                long_blk = ($urandom_range(0, 1) != 0);
                send_packet(long_blk, PK_GOOD,
                            long_blk ? $urandom_range(1, 12) : $urandom_range(1, 132), -1);
            end
            else if (pick < 80)
            begin
                send_beat(make_beat(1'b0, 8'($urandom), 8'($urandom)));
            end
            else if (pick < 92)
            begin
                case ($urandom_range(0, 2))
                    0: send_beat(make_beat(1'b0, BYTE_EOT, 8'($urandom)));
                    1: send_beat(make_beat(1'b0, BYTE_CAN, 8'($urandom)));
                    default: send_random_timeout();
                endcase
            end
            else
            begin
                idle_enable = ~idle_enable;
            end
        end
        idle_enable = 1'b1;
    endtask

    // Reset, test sequence and end of run
    initial
    begin
        rx_phase       = RX_IDLE;
        rx_long        = 1'b0;
        rx_seq         = '0;
        rx_exp         = '0;
        rx_pending     = '0;
        rx_count       = '0;
        rx_crc         = '0;
        rx_trailer_hi  = '0;
        mismatch_count = 0;
        live_items     = 0;
        idle_enable    = 1'b1;
        hold_request   = 1'b0;
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.data     = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_idle_events();
        test_midpacket_timeouts();
        test_short_statuses();
        test_long_packets();
        test_output_backpressure();
        test_random_traffic();

        @(negedge clk);
        rx_ch.valid = 1'b0;
        while (predicted_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
